// File: rtl/core/acctap_pkg.sv
// Shared types and constants for the accelerometer scale and tap detect core.
// No dependencies; used by the front, queue, back and top-level files of the block.
`default_nettype none

package acctap_pkg;

    localparam int AXIS_W    = 16;   // raw counts and internal milli-g values
    localparam int OUT_W     = 15;   // delivered milli-g fields
    localparam int FS_W      = 14;   // full_scale_mg register
    localparam int PROD_W    = AXIS_W + FS_W + 1;
    localparam int SCALE_SH  = 15;   // divide by 32768
    localparam int DELTA_W   = AXIS_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = FS_W;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_SOURCE      = 3'd0,
        CFG_Y_SOURCE      = 3'd1,
        CFG_Z_SOURCE      = 3'd2,
        CFG_INVERT_MASK   = 3'd3,
        CFG_FULL_SCALE_MG = 3'd4,
        CFG_POWER_ON      = 3'd5,
        CFG_STREAM_ENABLE = 3'd6,
        CFG_TAP_ENABLE    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SRC_AXIS0 = 2'd0,
        SRC_AXIS1 = 2'd1,
        SRC_AXIS2 = 2'd2,
        SRC_SAT   = 2'd3
    } t_src;

    typedef struct packed {
        logic [1:0]      x_source;
        logic [1:0]      y_source;
        logic [1:0]      z_source;
        logic [2:0]      invert_mask;
        logic [FS_W-1:0] full_scale_mg;
        logic            power_on;
        logic            stream_enable;
        logic            tap_enable;
    } t_cfg;

    // Classified tick as it travels from front to back
    typedef struct packed {
        logic [2:0][AXIS_W-1:0] axis;      // routed raw counts, negated where invert_mask is set
        logic                   hw_tap;
        logic                   sampled;
        logic                   delivered;
        logic                   tap_en;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/acctap_in_if.sv
// Input word channel: one sampling tick per word.
// Depends on nothing.
`default_nettype none

interface acctap_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic               hw_tap;

    modport source (output valid, output raw_x, output raw_y, output raw_z,
                    output hw_tap, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z,
                    input hw_tap, output ready);
endinterface

`default_nettype wire

// File: rtl/core/acctap_out_if.sv
// Result word channel: one converted sample and tap flag per tick.
// Depends on nothing.
`default_nettype none

interface acctap_out_if;
    logic               valid;
    logic               ready;
    logic               sample_valid;
    logic signed [14:0] accel_x_mg;
    logic signed [14:0] accel_y_mg;
    logic signed [14:0] accel_z_mg;
    logic               tap_event;

    modport source (output valid, output sample_valid, output accel_x_mg,
                    output accel_y_mg, output accel_z_mg, output tap_event,
                    input ready);
    modport sink   (input valid, input sample_valid, input accel_x_mg,
                    input accel_y_mg, input accel_z_mg, input tap_event,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/acctap_front.sv
// Front end: accepts ticks, routes and optionally negates axes, classifies the tick.
// Depends on acctap_pkg and acctap_in_if.
`default_nettype none

module acctap_front (
    acctap_in_if.sink            i_in,
    input  var acctap_pkg::t_cfg i_cfg,
    input  var logic             i_q_full,
    output logic                 o_push,
    output acctap_pkg::t_cmd     o_cmd
);

    logic [2:0][acctap_pkg::AXIS_W-1:0] raw;
    logic [2:0][1:0]                    sel;

    assign raw[0] = i_in.raw_x;
    assign raw[1] = i_in.raw_y;
    assign raw[2] = i_in.raw_z;
    assign sel[0] = i_cfg.x_source;
    assign sel[1] = i_cfg.y_source;
    assign sel[2] = i_cfg.z_source;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        logic [acctap_pkg::AXIS_W-1:0] v;
        for (int i = 0; i < 3; i++) begin
            unique case (acctap_pkg::t_src'(sel[i]))
                acctap_pkg::SRC_AXIS0: v = raw[0];
                acctap_pkg::SRC_AXIS1: v = raw[1];
                acctap_pkg::SRC_AXIS2: v = raw[2];
                acctap_pkg::SRC_SAT:   v = raw[2];
            endcase
            if (i_cfg.invert_mask[i]) begin
                // most negative count has no positive twin: clamp
                if (v == {1'b1, {(acctap_pkg::AXIS_W-1){1'b0}}}) begin
                    o_cmd.axis[i] = {1'b0, {(acctap_pkg::AXIS_W-1){1'b1}}};
                end else begin
                    o_cmd.axis[i] = -v;
                end
            end else begin
                o_cmd.axis[i] = v;
            end
        end
        o_cmd.hw_tap    = i_in.hw_tap;
        o_cmd.sampled   = i_cfg.power_on && (i_cfg.stream_enable || i_cfg.tap_enable);
        o_cmd.delivered = i_cfg.power_on && i_cfg.stream_enable;
        o_cmd.tap_en    = i_cfg.tap_enable;
    end

endmodule

`default_nettype wire

// File: rtl/core/acctap_fifo.sv
// Short queue of classified ticks between front and back.
// Depends on acctap_pkg.
`default_nettype none

module acctap_fifo (
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var logic             i_push,
    input  var acctap_pkg::t_cmd i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  var logic             i_pop,
    output acctap_pkg::t_cmd     o_data
);

    localparam int PTR_W = (acctap_pkg::Q_DEPTH > 1) ? $clog2(acctap_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(acctap_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(acctap_pkg::Q_DEPTH - 1);

    acctap_pkg::t_cmd  r_mem [acctap_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(acctap_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/acctap_back.sv
// Back end: scale multiply stage, then scaling fix-up, tap decision, state
// update and the output register. Depends on acctap_pkg and acctap_out_if.
`default_nettype none

module acctap_back #(
    parameter int TAP_THRESHOLD_MG = 1500,
    parameter int COOLDOWN_TICKS   = 8
) (
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var acctap_pkg::t_cfg i_cfg,
    input  var logic             i_q_valid,
    input  var acctap_pkg::t_cmd i_cmd,
    output logic                 o_pop,
    acctap_out_if.source         o_out
);

    localparam int AW = acctap_pkg::AXIS_W;
    localparam int PW = acctap_pkg::PROD_W;
    localparam int DW = acctap_pkg::DELTA_W;
    localparam int OW = acctap_pkg::OUT_W;
    localparam int SH = acctap_pkg::SCALE_SH;
    localparam int CD_W = $clog2(COOLDOWN_TICKS + 1);
    localparam logic [CD_W-1:0] CD_RELOAD = CD_W'(COOLDOWN_TICKS);
    localparam logic [DW-1:0]   THRESH    = DW'(TAP_THRESHOLD_MG);
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'((1 << SH) - 1);

    // multiply stage
    logic                        r_b_valid;
    logic signed [PW-1:0]        r_b_prod [3];
    logic                        r_b_hw_tap, r_b_sampled, r_b_delivered, r_b_tap_en;
    logic signed [PW-1:0]        n_b_prod [3];

    // tap state
    logic signed [AW-1:0]        r_prev [3];
    logic                        r_prev_valid;
    logic [CD_W-1:0]             r_cd, n_cd;

    // output register
    logic                        r_o_valid;
    logic                        r_o_sample_valid, r_o_tap;
    logic signed [OW-1:0]        r_o_axis [3];

    logic                        out_en, b_load, fire;
    logic signed [AW-1:0]        scaled [3];
    logic [DW-1:0]               delta;
    logic [CD_W-1:0]             cd_dec;
    logic                        cd_zero, sw_tap, hw_tap, tap;

    assign out_en = !r_o_valid || o_out.ready;
    assign b_load = !r_b_valid || out_en;
    assign fire   = r_b_valid && out_en;
    assign o_pop  = i_q_valid && b_load;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_prod[i] = $signed(i_cmd.axis[i]) * $signed({1'b0, i_cfg.full_scale_mg});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            for (int i = 0; i < 3; i++) begin
                r_b_prod[i] <= n_b_prod[i];
            end
            r_b_hw_tap    <= i_cmd.hw_tap;
            r_b_sampled   <= i_cmd.sampled;
            r_b_delivered <= i_cmd.delivered;
            r_b_tap_en    <= i_cmd.tap_en;
        end
    end

    // divide by 32768 toward zero, then sum of absolute differences
    always_comb begin
        logic signed [PW-1:0] biased;
        logic signed [AW:0]   d;
        logic [AW:0]          ad;
        delta = '0;
        for (int i = 0; i < 3; i++) begin
            biased    = r_b_prod[i] + (r_b_prod[i][PW-1] ? ROUND_BIAS : PW'(0));
            scaled[i] = biased[SH+AW-1:SH];
            d         = {scaled[i][AW-1], scaled[i]} - {r_prev[i][AW-1], r_prev[i]};
            ad        = d[AW] ? -d : d;
            delta     = delta + DW'(ad);
        end
    end

    always_comb begin
        cd_dec  = (r_cd != '0) ? r_cd - CD_W'(1) : '0;
        cd_zero = (cd_dec == '0);
        sw_tap  = r_b_sampled && r_prev_valid && r_b_tap_en && (delta >= THRESH) && cd_zero;
        // a software tap reloads the cooldown first and masks the sensor bit
        hw_tap  = r_b_tap_en && r_b_hw_tap && cd_zero && !sw_tap;
        tap     = sw_tap || hw_tap;
        n_cd    = tap ? CD_RELOAD : cd_dec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd         <= '0;
            r_prev_valid <= 1'b0;
            r_o_valid    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            if (fire) begin
                r_cd      <= n_cd;
                r_o_valid <= 1'b1;
                if (r_b_sampled) begin
                    r_prev_valid <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        r_prev[i] <= scaled[i];
                    end
                end
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_sample_valid <= r_b_delivered;
            r_o_tap          <= tap;
            for (int i = 0; i < 3; i++) begin
                r_o_axis[i] <= r_b_delivered ? scaled[i][OW-1:0] : '0;
            end
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.sample_valid = r_o_sample_valid;
    assign o_out.accel_x_mg   = r_o_axis[0];
    assign o_out.accel_y_mg   = r_o_axis[1];
    assign o_out.accel_z_mg   = r_o_axis[2];
    assign o_out.tap_event    = r_o_tap;

endmodule

`default_nettype wire

// File: rtl/core/accel_sample_scale_and_tap_detect_core.sv
// Accelerometer scale and tap detect core: one result word per input word.
// Throughput one word per cycle while the sink accepts; each result passes through
// the queue, multiply register and output register, and is held while the sink stalls.
// The cooldown and previous-sample registers each close a loop on themselves.
// Synchronous active-low reset empties the pipeline, clears tap state and
// loads the configuration defaults.
`default_nettype none

module accel_sample_scale_and_tap_detect_core #(
    parameter int TAP_THRESHOLD_MG = 1500,
    parameter int COOLDOWN_TICKS   = 8
) (
    input  var logic                                 i_clk,
    input  var logic                                 i_rst_n,
    acctap_in_if.sink                                i_in,
    acctap_out_if.source                             o_out,
    input  var logic                                 i_cfg_we,
    input  var logic [acctap_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  var logic [acctap_pkg::CFG_W-1:0]         i_cfg_data
);

    acctap_pkg::t_cfg r_cfg;
    acctap_pkg::t_cmd push_cmd, head_cmd;
    logic             push, q_full, q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_source      <= 2'd0;
            r_cfg.y_source      <= 2'd1;
            r_cfg.z_source      <= 2'd2;
            r_cfg.invert_mask   <= 3'd0;
            r_cfg.full_scale_mg <= acctap_pkg::FS_W'(2000);
            r_cfg.power_on      <= 1'b1;
            r_cfg.stream_enable <= 1'b0;
            r_cfg.tap_enable    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (acctap_pkg::t_cfg_idx'(i_cfg_idx))
                acctap_pkg::CFG_X_SOURCE:      r_cfg.x_source      <= i_cfg_data[1:0];
                acctap_pkg::CFG_Y_SOURCE:      r_cfg.y_source      <= i_cfg_data[1:0];
                acctap_pkg::CFG_Z_SOURCE:      r_cfg.z_source      <= i_cfg_data[1:0];
                acctap_pkg::CFG_INVERT_MASK:   r_cfg.invert_mask   <= i_cfg_data[2:0];
                acctap_pkg::CFG_FULL_SCALE_MG: r_cfg.full_scale_mg <= i_cfg_data;
                acctap_pkg::CFG_POWER_ON:      r_cfg.power_on      <= i_cfg_data[0];
                acctap_pkg::CFG_STREAM_ENABLE: r_cfg.stream_enable <= i_cfg_data[0];
                acctap_pkg::CFG_TAP_ENABLE:    r_cfg.tap_enable    <= i_cfg_data[0];
            endcase
        end
    end

    acctap_front u_front (
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    acctap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (head_cmd)
    );

    acctap_back #(
        .TAP_THRESHOLD_MG (TAP_THRESHOLD_MG),
        .COOLDOWN_TICKS   (COOLDOWN_TICKS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
